// File: sv/ytp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ytp_pkg
// Types and constants of the YUV test pattern pixel source.
// ----------------------------------------------------------------------------
package ytp_pkg;

	localparam int COORD_BITS   = 12;
	localparam int GRID_BITS    = 4;
	localparam int BAND_BITS    = COORD_BITS - GRID_BITS;
	localparam int BYTE_BITS    = 8;
	localparam int NUM_BITS     = COORD_BITS + BYTE_BITS;
	localparam int DIV_STAGES   = NUM_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(640);
	localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(480);
	localparam logic [COORD_BITS-1:0] MIN_WIDTH    = COORD_BITS'(4);

	localparam logic [BAND_BITS-1:0] BAR_BANDS  = BAND_BITS'(12);
	localparam logic [BAND_BITS-1:0] FLAT_BANDS = BAND_BITS'(4);
	localparam logic [BAND_BITS-1:0] BAND_FOUR  = BAND_BITS'(4);
	localparam logic [BAND_BITS-1:0] BAND_FIVE  = BAND_BITS'(5);

	localparam logic [BYTE_BITS-1:0] LUMA_GRID   = 8'hF0;
	localparam logic [BYTE_BITS-1:0] BAR_BASE    = 8'h10;
	localparam logic [BYTE_BITS-1:0] RAMP_BASE   = 8'h20;
	localparam logic [BYTE_BITS-1:0] CHROMA_FLAT = 8'h80;
	localparam logic [BYTE_BITS-1:0] CHROMA_30   = 8'h30;
	localparam logic [BYTE_BITS-1:0] CHROMA_C0   = 8'hC0;
	localparam logic [BYTE_BITS-1:0] CHROMA_10   = 8'h10;
	localparam logic [BYTE_BITS-1:0] CHROMA_F0   = 8'hF0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CH_FLAT  = 2'd0,
		CH_BAND4 = 2'd1,
		CH_BAND5 = 2'd2,
		CH_RAMP  = 2'd3
	} chroma_sel_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x_pos;
		logic [COORD_BITS-1:0] y_pos;
	} coord_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] luma;
		logic [BYTE_BITS-1:0] chroma;
		logic                 frame_end;
	} pixel_t;

	typedef struct packed {
		logic        grid;
		logic        bar;
		chroma_sel_t csel;
		logic        right;
		logic        odd;
		logic        last;
	} side_t;

endpackage
`default_nettype wire

// File: sv/yuv_test_pattern_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from coordinate beat to pixel valid: input stage, one restoring
// divide step per stage over 20 dividend bits, output mux, output reg.
// Throughput: one pixel per cycle, but none while the skid holds a beat;
// the divide pipeline sets the depth. A skid register behind the output keeps
// coord_ready registered. Reset: width 640, height 480, pipeline empty.
// ----------------------------------------------------------------------------
// yuv_test_pattern_pixel
// Test picture source: grid, bars and ramp luma, banded chroma per pixel.
// ----------------------------------------------------------------------------
module yuv_test_pattern_pixel import ytp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    coord_valid,
	output logic                         coord_ready,
	input  wire coord_t                  coord,
	output logic                         pixel_valid,
	input  wire logic                    pixel_ready,
	output pixel_t                       pixel,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]   cfg_data
);

	logic [COORD_BITS-1:0] width_q, height_q;
	logic [COORD_BITS-1:0] w_eff, quarter_w, half_w;

	logic en, take;

	logic                  v_s1;
	logic [NUM_BITS-1:0]   nr_s1, nb_s1;
	side_t                 side_s1, side_in;

	logic                  v_s2    [DIV_STAGES];
	logic [NUM_BITS-1:0]   nr_s2   [DIV_STAGES];
	logic [NUM_BITS-1:0]   nb_s2   [DIV_STAGES];
	logic [COORD_BITS-1:0] rr_s2   [DIV_STAGES];
	logic [COORD_BITS-1:0] rb_s2   [DIV_STAGES];
	logic [BYTE_BITS-1:0]  qr_s2   [DIV_STAGES];
	logic [BYTE_BITS-1:0]  qb_s2   [DIV_STAGES];
	side_t                 side_s2 [DIV_STAGES];

	logic [NUM_BITS-1:0]   src_nr [DIV_STAGES];
	logic [NUM_BITS-1:0]   src_nb [DIV_STAGES];
	logic [COORD_BITS-1:0] src_rr [DIV_STAGES];
	logic [COORD_BITS-1:0] src_rb [DIV_STAGES];
	logic [BYTE_BITS-1:0]  src_qr [DIV_STAGES];
	logic [BYTE_BITS-1:0]  src_qb [DIV_STAGES];
	side_t                 src_sd [DIV_STAGES];
	logic [COORD_BITS:0]   tr_r   [DIV_STAGES];
	logic [COORD_BITS:0]   tr_b   [DIV_STAGES];
	logic                  ge_r   [DIV_STAGES];
	logic                  ge_b   [DIV_STAGES];

	logic                  v_s3;
	pixel_t                pix_s3, pix_nxt;

	logic                  skid_valid_q;
	pixel_t                skid_q;

	logic [BAND_BITS-1:0]  band;
	logic [BYTE_BITS-1:0]  qr_end, qb_end, bar_luma, ramp_byte;
	side_t                 sd_end;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff     = (width_q < MIN_WIDTH) ? MIN_WIDTH : width_q;
	assign quarter_w = w_eff >> 2;
	assign half_w    = w_eff >> 1;

	assign en          = !skid_valid_q;
	assign coord_ready = en;
	assign take        = coord_valid && en;

	// input stage: per-pixel flags and dividends
	assign band = coord.y_pos[COORD_BITS-1:GRID_BITS];

	always_comb begin
		side_in.grid  = (coord.x_pos[GRID_BITS-1:0] == '0) ||
		                (coord.y_pos[GRID_BITS-1:0] == '0);
		side_in.bar   = band < BAR_BANDS;
		if (band < FLAT_BANDS)
			side_in.csel = CH_FLAT;
		else if (band == BAND_FOUR)
			side_in.csel = CH_BAND4;
		else if (band == BAND_FIVE)
			side_in.csel = CH_BAND5;
		else
			side_in.csel = CH_RAMP;
		side_in.right = coord.x_pos >= half_w;
		side_in.odd   = coord.x_pos[0];
		side_in.last  = (height_q != '0) &&
		                (coord.x_pos == w_eff - COORD_BITS'(1)) &&
		                (coord.y_pos == height_q - COORD_BITS'(1));
	end

	// divide steps: ramp 192*x / w and bar x / (w/4), one quotient bit per stage
	always_comb begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			if (i == 0) begin
				src_nr[i] = nr_s1;
				src_nb[i] = nb_s1;
				src_rr[i] = '0;
				src_rb[i] = '0;
				src_qr[i] = '0;
				src_qb[i] = '0;
				src_sd[i] = side_s1;
			end else begin
				src_nr[i] = nr_s2[i-1];
				src_nb[i] = nb_s2[i-1];
				src_rr[i] = rr_s2[i-1];
				src_rb[i] = rb_s2[i-1];
				src_qr[i] = qr_s2[i-1];
				src_qb[i] = qb_s2[i-1];
				src_sd[i] = side_s2[i-1];
			end
			tr_r[i] = {src_rr[i], src_nr[i][NUM_BITS-1]};
			tr_b[i] = {src_rb[i], src_nb[i][NUM_BITS-1]};
			ge_r[i] = tr_r[i] >= {1'b0, w_eff};
			ge_b[i] = tr_b[i] >= {1'b0, quarter_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++)
				v_s2[i] <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2[0] <= v_s1;
			for (int i = 1; i < DIV_STAGES; i++)
				v_s2[i] <= v_s2[i-1];
			v_s3 <= v_s2[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s1   <= NUM_BITS'({coord.x_pos, 7'b0}) + NUM_BITS'({coord.x_pos, 6'b0});
			nb_s1   <= NUM_BITS'(coord.x_pos);
			side_s1 <= side_in;
			for (int i = 0; i < DIV_STAGES; i++) begin
				nr_s2[i]   <= src_nr[i] << 1;
				nb_s2[i]   <= src_nb[i] << 1;
				rr_s2[i]   <= ge_r[i] ? COORD_BITS'(tr_r[i] - {1'b0, w_eff})
				                      : tr_r[i][COORD_BITS-1:0];
				rb_s2[i]   <= ge_b[i] ? COORD_BITS'(tr_b[i] - {1'b0, quarter_w})
				                      : tr_b[i][COORD_BITS-1:0];
				qr_s2[i]   <= {src_qr[i][BYTE_BITS-2:0], ge_r[i]};
				qb_s2[i]   <= {src_qb[i][BYTE_BITS-2:0], ge_b[i]};
				side_s2[i] <= src_sd[i];
			end
			pix_s3 <= pix_nxt;
		end
	end

	// pixel bytes
	assign qr_end    = qr_s2[DIV_STAGES-1];
	assign qb_end    = qb_s2[DIV_STAGES-1];
	assign sd_end    = side_s2[DIV_STAGES-1];
	assign bar_luma  = BAR_BASE + BYTE_BITS'({qb_end, 4'b0}) + BYTE_BITS'({qb_end, 5'b0});
	assign ramp_byte = RAMP_BASE + qr_end;

	always_comb begin
		if (sd_end.grid)
			pix_nxt.luma = LUMA_GRID;
		else if (sd_end.bar)
			pix_nxt.luma = bar_luma;
		else
			pix_nxt.luma = ramp_byte;
		case (sd_end.csel)
			CH_FLAT:  pix_nxt.chroma = CHROMA_FLAT;
			CH_BAND4: pix_nxt.chroma = (sd_end.right ^ sd_end.odd) ? CHROMA_C0 : CHROMA_30;
			CH_BAND5: pix_nxt.chroma = sd_end.odd ? CHROMA_FLAT
			                         : (sd_end.right ? CHROMA_10 : CHROMA_F0);
			CH_RAMP:  pix_nxt.chroma = ramp_byte;
			default:  pix_nxt.chroma = CHROMA_FLAT;
		endcase
		pix_nxt.frame_end = sd_end.last;
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pixel_ready || !pixel_valid) begin
			if (skid_valid_q) begin
				pixel_valid  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				pixel_valid <= v_s3 && en;
			end
		end else if (v_s3 && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_ready || !pixel_valid) begin
			pixel <= skid_valid_q ? skid_q : pix_s3;
		end else if (v_s3 && en) begin
			skid_q <= pix_s3;
		end
	end

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> pixel_valid)
		else $error("skid holds a beat while output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(pixel_valid && !pixel_ready))
		else $error("skid filled without an output stall");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1) |=> v_s2[0])
		else $error("beat lost entering divide pipeline");

endmodule
`default_nettype wire
